// ===== design/psv_pkg.sv =====
// ----------------------------------------------------------------------------
// psv_pkg
// Shared types, constants and helper functions of the plucked string voice.
// ----------------------------------------------------------------------------
package psv_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int ACC_W       = 54;
    localparam int RATE_W      = 18;
    localparam int VEL_W       = 17;
    localparam int MIX_W       = 17;
    localparam int SNAP_W      = 16;
    localparam int PER_IN_W    = 12;
    localparam int STEP_W      = 20;
    localparam int COEF_W      = 16;
    localparam int STRIDE_W    = 26;
    localparam int PHASE_W     = 27;
    localparam int ENV_W       = 17;
    localparam int LFSR_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 18;
    localparam int DIV_NUM_W   = 42;
    localparam int DIV_DEN_W   = 26;
    localparam int MAX_STR_LEN = 2048;

    // floor(n/5) = (n * 52429) >> 18 for any n below 2^16
    localparam logic [31:0] DIV5_RECIP = 32'd52429;
    localparam int          DIV5_SHIFT = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_METALLIC_MIX  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SNAP_EXPONENT = 2'd3;

    localparam logic [ENV_W-1:0]    ONE_Q16    = 17'd65536;
    localparam logic [LFSR_W-1:0]   LFSR_SEED  = 16'hACE1;
    localparam logic [LFSR_W-1:0]   LFSR_TAPS  = 16'hB400;
    localparam logic [RATE_W-1:0]   RATE_MIN   = 18'd8000;
    localparam logic [RATE_W-1:0]   RATE_MAX   = 18'd192000;
    localparam logic [RATE_W-1:0]   RATE_RST   = 18'd48000;
    localparam logic [VEL_W-1:0]    VEL_RST    = 17'd65536;
    localparam logic [MIX_W-1:0]    MIX_RST    = 17'd10486;
    localparam logic [SNAP_W-1:0]   SNAP_RST   = 16'd18022;
    localparam logic [STEP_W-1:0]   STEP_RST   = 20'd112640;
    localparam logic [STRIDE_W-1:0] STRIDE_RST = 26'd12288000;

    localparam logic [ACC_W-1:0] SAT_POS = ACC_W'(2**(SAMPLE_W-1) - 1);
    localparam logic [ACC_W-1:0] SAT_NEG = ACC_W'(2**(SAMPLE_W-1));

    typedef struct packed {
        logic                pluck;
        logic [PER_IN_W-1:0] period;
        logic [STEP_W-1:0]   step;
        logic [COEF_W-1:0]   tension;
        logic [COEF_W-1:0]   damping;
    } t_cmd;

    typedef logic [29:0] t_exp_tab [0:16];

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = '0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (b > n) b = b >> 2;
        end
        for (int k = 0; k < 32; k++) begin
            if (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // 2^-(2^-j) in Q0.30, by repeated square roots of one half
    function automatic t_exp_tab exp_tab_init();
        t_exp_tab    t;
        logic [63:0] v;
        v = 64'd1 << 29;
        t[0] = 30'(v);
        for (int j = 1; j <= 16; j++) begin
            v = isqrt64(v << 30);
            t[j] = 30'(v);
        end
        return t;
    endfunction

    localparam t_exp_tab EXP_TAB = exp_tab_init();

    // shift right with rounding half away from zero, then saturate
    function automatic logic signed [SAMPLE_W-1:0] rs_sat(
        input logic signed [ACC_W-1:0] v,
        input int                      s
    );
        logic [ACC_W-1:0] mag;
        logic [ACC_W:0]   rnd;
        logic [ACC_W-1:0] q;
        mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        rnd = {1'b0, mag} + ((ACC_W+1)'(1) << (s - 1));
        q   = ACC_W'(rnd >> s);
        if (!v[ACC_W-1]) begin
            return (q > SAT_POS) ? SAMPLE_W'(SAT_POS) : q[SAMPLE_W-1:0];
        end
        return (q > SAT_NEG) ? SAMPLE_W'(SAT_NEG) : SAMPLE_W'(-q[SAMPLE_W-1:0]);
    endfunction

endpackage

// ===== design/plucked_string_synth_voice.sv =====
// ----------------------------------------------------------------------------
// plucked_string_synth_voice
// Plucked-string voice: one input item per audio sample, one sample out.
//
// Input items are pushed while full is low; samples are taken with pop
// while empty is low. A rising trigger_level latches the note fields and
// refills the string. Configuration writes are registered; they are
// meant for idle periods and take effect on the next pluck.
// A plain item gives its sample after it leaves the two-entry input
// queue and passes the radix-2 divider that forms the interpolation
// fraction. Each string cell passed adds a trip through the string
// memory. A pluck adds one divide, and for each cell of the new period
// an envelope division and a pass through the log/exp power unit.
// After reset the string memory is cleared while full stays high. While
// the result register is not popped the sequencer holds its sample and
// the input queue keeps taking items until full.
// ----------------------------------------------------------------------------
module plucked_string_synth_voice
    import psv_pkg::*;
#(
    parameter int MAX_STRING_LEN = MAX_STR_LEN
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       i_trigger_level,
    input  logic [PER_IN_W-1:0]        i_note_period,
    input  logic [STEP_W-1:0]          i_note_step,
    input  logic [COEF_W-1:0]          i_tension_coef,
    input  logic [COEF_W-1:0]          i_damping_coef,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SAMPLE_W-1:0] o_audio_sample,
    input  logic                       i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    logic [RATE_W-1:0] r_rate;
    logic [VEL_W-1:0]  r_vel;
    logic [MIX_W-1:0]  r_mix;
    logic [SNAP_W-1:0] r_snap;

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_pop;
    logic w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RST;
            r_vel  <= VEL_RST;
            r_mix  <= MIX_RST;
            r_snap <= SNAP_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SAMPLE_RATE:   r_rate <= i_cfg_data;
                CFG_VELOCITY:      r_vel  <= i_cfg_data[VEL_W-1:0];
                CFG_METALLIC_MIX:  r_mix  <= i_cfg_data[MIX_W-1:0];
                CFG_SNAP_EXPONENT: r_snap <= i_cfg_data[SNAP_W-1:0];
                default: ;
            endcase
        end
    end

    psv_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_hold          (w_busy),
        .i_trigger_level (i_trigger_level),
        .i_note_period   (i_note_period),
        .i_note_step     (i_note_step),
        .i_tension_coef  (i_tension_coef),
        .i_damping_coef  (i_damping_coef),
        .i_cmd_pop       (w_cmd_pop),
        .o_full          (full),
        .o_cmd_valid     (w_cmd_valid),
        .o_cmd           (w_cmd)
    );

    psv_back #(
        .MAX_STRING_LEN (MAX_STRING_LEN)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_cmd_valid),
        .i_cmd          (w_cmd),
        .o_cmd_pop      (w_cmd_pop),
        .o_busy         (w_busy),
        .i_rate         (r_rate),
        .i_vel          (r_vel),
        .i_mix          (r_mix),
        .i_snap         (r_snap),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_audio_sample (o_audio_sample)
    );

endmodule

// ===== design/psv_div.sv =====
// ----------------------------------------------------------------------------
// psv_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psv_div
    import psv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] r_q;

    logic [DIV_DEN_W:0]   w_t;
    logic [DIV_DEN_W:0]   w_sub;
    logic                 w_ge;

    always_comb begin
        w_t   = {r_rem, r_q[DIV_NUM_W-1]};
        w_ge  = w_t >= {1'b0, r_den};
        w_sub = w_t - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NUM_W - 1);
                r_rem  <= '0;
                r_q    <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sub[DIV_DEN_W-1:0] : w_t[DIV_DEN_W-1:0];
                r_q   <= {r_q[DIV_NUM_W-2:0], w_ge};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== design/psv_pow.sv =====
// ----------------------------------------------------------------------------
// psv_pow
// Fixed-point power x^p as 2^(p*log2 x): bitwise log, then table exponent.
// ----------------------------------------------------------------------------
module psv_pow
    import psv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ENV_W-1:0]  i_x,
    input  logic [SNAP_W-1:0] i_p,
    output logic              o_done,
    output logic [ENV_W-1:0]  o_res
);

    typedef enum logic [2:0] {
        PW_IDLE, PW_NORM, PW_LOG, PW_MAG, PW_EXP, PW_FIN
    } t_pw_state;

    t_pw_state         r_state;
    logic              r_done;
    logic [ENV_W-1:0]  r_res;
    logic [15:0]       r_x;
    logic [3:0]        r_n;
    logic [3:0]        r_j;
    logic [30:0]       r_m;
    logic [15:0]       r_lg;
    logic [SNAP_W-1:0] r_p;
    logic [4:0]        r_q;
    logic [15:0]       r_f;
    logic [30:0]       r_r;

    logic [61:0]       w_sq;
    logic [20:0]       w_mag;
    logic [36:0]       w_yp;
    logic [24:0]       w_y;
    logic [60:0]       w_rm;
    logic [31:0]       w_fin;

    always_comb begin
        w_sq  = {31'b0, r_m} * {31'b0, r_m};
        w_mag = {5'({1'b0, r_n} + 5'd1), 16'b0} - {5'b0, r_lg};
        w_yp  = {16'b0, w_mag} * {21'b0, r_p};
        w_y   = w_yp[36:12];
        w_rm  = {30'b0, r_r} * {31'b0, EXP_TAB[5'({1'b0, r_j} + 5'd1)]};
        w_fin = {1'b0, r_r >> r_q} + 32'd8192;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PW_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                PW_IDLE: begin
                    if (i_start) begin
                        r_p <= i_p;
                        if (i_p == '0 || i_x[ENV_W-1]) begin
                            r_res  <= ONE_Q16;
                            r_done <= 1'b1;
                        end else if (i_x == '0) begin
                            r_res  <= '0;
                            r_done <= 1'b1;
                        end else begin
                            r_x     <= i_x[15:0];
                            r_n     <= '0;
                            r_state <= PW_NORM;
                        end
                    end
                end
                PW_NORM: begin
                    if (r_x[15]) begin
                        r_m     <= {r_x, 15'b0};
                        r_j     <= '0;
                        r_state <= PW_LOG;
                    end else begin
                        r_x <= {r_x[14:0], 1'b0};
                        r_n <= r_n + 1'b1;
                    end
                end
                PW_LOG: begin
                    r_m  <= w_sq[61] ? w_sq[61:31] : w_sq[60:30];
                    r_lg <= {r_lg[14:0], w_sq[61]};
                    r_j  <= r_j + 1'b1;
                    if (r_j == 4'd15) r_state <= PW_MAG;
                end
                PW_MAG: begin
                    if (w_y[24:16] >= 9'd31) begin
                        r_res   <= '0;
                        r_done  <= 1'b1;
                        r_state <= PW_IDLE;
                    end else begin
                        r_q     <= w_y[20:16];
                        r_f     <= w_y[15:0];
                        r_r     <= 31'd1 << 30;
                        r_j     <= '0;
                        r_state <= PW_EXP;
                    end
                end
                PW_EXP: begin
                    if (r_f[15]) r_r <= w_rm[60:30];
                    r_f <= {r_f[14:0], 1'b0};
                    r_j <= r_j + 1'b1;
                    if (r_j == 4'd15) r_state <= PW_FIN;
                end
                PW_FIN: begin
                    r_res   <= w_fin[30:14];
                    r_done  <= 1'b1;
                    r_state <= PW_IDLE;
                end
                default: r_state <= PW_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== design/psv_front.sv =====
// ----------------------------------------------------------------------------
// psv_front
// Input side: trigger edge detection and a two-entry command queue.
// ----------------------------------------------------------------------------
module psv_front
    import psv_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic                i_hold,
    input  logic                i_trigger_level,
    input  logic [PER_IN_W-1:0] i_note_period,
    input  logic [STEP_W-1:0]   i_note_step,
    input  logic [COEF_W-1:0]   i_tension_coef,
    input  logic [COEF_W-1:0]   i_damping_coef,
    input  logic                i_cmd_pop,
    output logic                o_full,
    output logic                o_cmd_valid,
    output t_cmd                o_cmd
);

    t_cmd       r_q [0:1];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       r_prev;
    logic       w_acc;
    logic       w_pop;

    assign o_full      = (r_cnt == 2'd2) || i_hold;
    assign o_cmd_valid = r_cnt != 2'd0;
    assign o_cmd       = r_q[r_rp];
    assign w_acc       = i_push && !o_full;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_cnt  <= '0;
            r_prev <= 1'b0;
        end else begin
            if (w_acc) begin
                r_q[r_wp] <= '{pluck:   i_trigger_level && !r_prev,
                               period:  i_note_period,
                               step:    i_note_step,
                               tension: i_tension_coef,
                               damping: i_damping_coef};
                r_wp   <= !r_wp;
                r_prev <= i_trigger_level;
            end
            if (w_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_acc} - {1'b0, w_pop};
        end
    end

endmodule

// ===== design/psv_back.sv =====
// ----------------------------------------------------------------------------
// psv_back
// Sequencer: string refill on pluck, interpolated output, filtered feedback.
// ----------------------------------------------------------------------------
module psv_back
    import psv_pkg::*;
#(
    parameter int MAX_STRING_LEN = MAX_STR_LEN
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  t_cmd                       i_cmd,
    output logic                       o_cmd_pop,
    output logic                       o_busy,
    input  logic [RATE_W-1:0]          i_rate,
    input  logic [VEL_W-1:0]           i_vel,
    input  logic [MIX_W-1:0]           i_mix,
    input  logic [SNAP_W-1:0]          i_snap,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic signed [SAMPLE_W-1:0] o_audio_sample
);

    localparam int AW = $clog2(MAX_STRING_LEN);
    localparam int PW = $clog2(MAX_STRING_LEN + 1);

    typedef enum logic [4:0] {
        ST_CLR, ST_IDLE,
        ST_PL_PIV, ST_PL_STR, ST_PL_STRW,
        ST_PL_ENV, ST_PL_ENVW, ST_PL_POW, ST_PL_POWW,
        ST_PL_MIX, ST_PL_ADD, ST_PL_VEL, ST_PL_WR,
        ST_SMP_RD0, ST_SMP_RD1, ST_SMP_C1, ST_SMP_DIVW,
        ST_SMP_MA, ST_SMP_MB, ST_SMP_OUT,
        ST_LP_CHK, ST_LP_RD, ST_LP_MB, ST_LP_MD, ST_LP_WR
    } t_state;

    logic signed [SAMPLE_W-1:0] r_mem [0:MAX_STRING_LEN-1];
    logic signed [SAMPLE_W-1:0] r_rd;

    t_state                     r_state;
    logic [AW-1:0]              r_clr;
    logic [PW-1:0]              r_per;
    logic [PW-1:0]              r_pivot;
    logic [PW-1:0]              r_idx;
    logic [STEP_W-1:0]          r_step;
    logic [COEF_W-1:0]          r_ten;
    logic [COEF_W-1:0]          r_damp;
    logic [STRIDE_W-1:0]        r_stride;
    logic [AW-1:0]              r_pos;
    logic [PHASE_W-1:0]         r_phase;
    logic signed [SAMPLE_W-1:0] r_filt;
    logic [LFSR_W-1:0]          r_lfsr;
    logic                       r_sgn;
    logic [ENV_W-1:0]           r_e;
    logic [ENV_W-1:0]           r_frac;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_c0;
    logic signed [SAMPLE_W-1:0] r_c1;
    logic signed [SAMPLE_W-1:0] r_out;
    logic                       r_out_valid;

    logic [PW-1:0]              w_per;
    logic [RATE_W-1:0]          w_rate;
    logic                       w_le;
    logic [PW-1:0]              w_env_k;
    logic [PW-1:0]              w_env_den;
    logic [31:0]                w_piv_prod;
    logic [AW-1:0]              w_pos_nx;
    logic [AW-1:0]              w_raddr;
    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic signed [SAMPLE_W-1:0] w_wdata;
    logic signed [SAMPLE_W-1:0] w_cell;
    logic signed [SAMPLE_W-1:0] w_dnew;
    logic                       w_div_start;
    logic [DIV_NUM_W-1:0]       w_div_num;
    logic [DIV_DEN_W-1:0]       w_div_den;
    logic                       w_div_done;
    logic [DIV_NUM_W-1:0]       w_div_quot;
    logic                       w_pow_done;
    logic [ENV_W-1:0]           w_pow_res;
    logic signed [18:0]         w_omm;
    logic signed [36:0]         w_mix_prod;
    logic signed [33:0]         w_mterm;
    logic signed [53:0]         w_vel_prod;
    logic [ENV_W-1:0]           w_omf;
    logic [ENV_W-1:0]           w_omt;
    logic signed [33:0]         w_ma_prod;
    logic signed [33:0]         w_mb_prod;
    logic signed [33:0]         w_fa_prod;
    logic signed [32:0]         w_fb_prod;
    logic signed [52:0]         w_fd_prod;
    logic                       w_out_free;

    always_comb begin
        if (i_cmd.period == '0) begin
            w_per = PW'(1);
        end else if (32'(i_cmd.period) > 32'(MAX_STRING_LEN)) begin
            w_per = PW'(MAX_STRING_LEN);
        end else begin
            w_per = PW'(i_cmd.period);
        end
        if (i_rate < RATE_MIN) w_rate = RATE_MIN;
        else if (i_rate > RATE_MAX) w_rate = RATE_MAX;
        else w_rate = i_rate;

        w_le       = r_idx <= r_pivot;
        w_env_k    = w_le ? r_idx : r_per - r_idx - PW'(1);
        w_env_den  = w_le ? r_pivot : r_per - r_pivot - PW'(1);
        w_piv_prod = 32'(r_per) * DIV5_RECIP;
        w_pos_nx   = (PW'(r_pos) + PW'(1) >= r_per) ? '0 : r_pos + 1'b1;

        w_omm      = 19'sd65536 - $signed({2'b00, i_mix});
        w_mix_prod = $signed({1'b0, r_e}) * w_omm;
        w_mterm    = $signed({1'b0, i_mix, 16'b0});
        w_vel_prod = $signed(r_acc[35:0]) * $signed({1'b0, i_vel});
        w_omf      = ONE_Q16 - r_frac;
        w_omt      = ONE_Q16 - {1'b0, r_ten};
        w_ma_prod  = r_c0 * $signed({1'b0, w_omf});
        w_mb_prod  = r_c1 * $signed({1'b0, r_frac});
        w_fa_prod  = r_filt * $signed({1'b0, w_omt});
        w_fb_prod  = r_c0 * $signed({1'b0, r_ten});
        w_fd_prod  = $signed(r_acc[35:0]) * $signed({1'b0, r_damp});
        w_cell     = rs_sat(r_acc, 33);
        w_dnew     = rs_sat(r_acc, 32);
        w_out_free = !r_out_valid || i_pop;

        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        case (r_state)
            ST_PL_STR: begin
                w_div_start = 1'b1;
                w_div_num   = DIV_NUM_W'({w_rate, 8'b0});
                w_div_den   = DIV_DEN_W'(r_per);
            end
            ST_PL_ENV: begin
                w_div_start = !(w_le && r_pivot == '0);
                w_div_num   = DIV_NUM_W'({w_env_k, 16'b0});
                w_div_den   = DIV_DEN_W'(w_env_den);
            end
            ST_SMP_C1: begin
                w_div_start = 1'b1;
                w_div_num   = {r_phase[STRIDE_W-1:0], 16'b0};
                w_div_den   = r_stride;
            end
            default: ;
        endcase

        w_raddr = r_pos;
        if (r_state == ST_SMP_RD1) w_raddr = w_pos_nx;

        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = w_dnew;
        case (r_state)
            ST_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
            end
            ST_PL_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[AW-1:0];
                w_wdata = w_cell;
            end
            ST_LP_WR: w_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd <= r_mem[w_raddr];
    end

    psv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    psv_pow u_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_PL_POW),
        .i_x     (r_e),
        .i_p     (i_snap),
        .o_done  (w_pow_done),
        .o_res   (w_pow_res)
    );

    assign o_cmd_pop      = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_busy         = r_state == ST_CLR;
    assign o_empty        = !r_out_valid;
    assign o_audio_sample = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr       <= '0;
            r_per       <= PW'(1);
            r_step      <= STEP_RST;
            r_ten       <= '0;
            r_damp      <= '0;
            r_stride    <= STRIDE_RST;
            r_pos       <= '0;
            r_phase     <= '0;
            r_filt      <= '0;
            r_lfsr      <= LFSR_SEED;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid) r_out_valid <= 1'b0;
            case (r_state)
                ST_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(MAX_STRING_LEN - 1)) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.pluck) begin
                            r_per   <= w_per;
                            r_step  <= i_cmd.step;
                            r_ten   <= i_cmd.tension;
                            r_damp  <= i_cmd.damping;
                            r_state <= ST_PL_PIV;
                        end else begin
                            r_state <= ST_SMP_RD0;
                        end
                    end
                end
                ST_PL_PIV: begin
                    r_pivot <= w_piv_prod[DIV5_SHIFT +: PW];
                    r_state <= ST_PL_STR;
                end
                ST_PL_STR:  r_state <= ST_PL_STRW;
                ST_PL_STRW: begin
                    if (w_div_done) begin
                        r_stride <= w_div_quot[STRIDE_W-1:0];
                        r_pos    <= '0;
                        r_phase  <= '0;
                        r_idx    <= '0;
                        r_state  <= ST_PL_ENV;
                    end
                end
                ST_PL_ENV: begin
                    if (w_le && r_pivot == '0) begin
                        r_e     <= ONE_Q16;
                        r_state <= ST_PL_POW;
                    end else begin
                        r_state <= ST_PL_ENVW;
                    end
                end
                ST_PL_ENVW: begin
                    if (w_div_done) begin
                        r_e     <= w_div_quot[ENV_W-1:0];
                        r_state <= ST_PL_POW;
                    end
                end
                ST_PL_POW:  r_state <= ST_PL_POWW;
                ST_PL_POWW: begin
                    if (w_pow_done) begin
                        r_e     <= w_pow_res;
                        r_state <= ST_PL_MIX;
                    end
                end
                ST_PL_MIX: begin
                    r_sgn   <= r_lfsr[0];
                    r_lfsr  <= (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : '0);
                    r_acc   <= ACC_W'(w_mix_prod);
                    r_state <= ST_PL_ADD;
                end
                ST_PL_ADD: begin
                    r_acc   <= r_sgn ? r_acc - ACC_W'(w_mterm) : r_acc + ACC_W'(w_mterm);
                    r_state <= ST_PL_VEL;
                end
                ST_PL_VEL: begin
                    r_acc   <= w_vel_prod;
                    r_state <= ST_PL_WR;
                end
                ST_PL_WR: begin
                    if (r_idx + PW'(1) == r_per) begin
                        r_state <= ST_SMP_RD0;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_PL_ENV;
                    end
                end
                ST_SMP_RD0: r_state <= ST_SMP_RD1;
                ST_SMP_RD1: begin
                    r_c0    <= r_rd;
                    r_state <= ST_SMP_C1;
                end
                ST_SMP_C1: begin
                    r_c1    <= r_rd;
                    r_state <= ST_SMP_DIVW;
                end
                ST_SMP_DIVW: begin
                    if (w_div_done) begin
                        r_frac  <= w_div_quot[ENV_W-1:0];
                        r_state <= ST_SMP_MA;
                    end
                end
                ST_SMP_MA: begin
                    r_acc   <= ACC_W'(w_ma_prod);
                    r_state <= ST_SMP_MB;
                end
                ST_SMP_MB: begin
                    r_acc   <= r_acc + ACC_W'(w_mb_prod);
                    r_state <= ST_SMP_OUT;
                end
                ST_SMP_OUT: begin
                    if (w_out_free) begin
                        r_out       <= rs_sat(r_acc, 16);
                        r_out_valid <= 1'b1;
                        r_phase     <= r_phase + PHASE_W'(r_step);
                        r_state     <= ST_LP_CHK;
                    end
                end
                ST_LP_CHK: begin
                    if (r_phase >= {1'b0, r_stride}) r_state <= ST_LP_RD;
                    else r_state <= ST_IDLE;
                end
                ST_LP_RD: begin
                    r_c0    <= r_rd;
                    r_acc   <= ACC_W'(w_fa_prod);
                    r_state <= ST_LP_MB;
                end
                ST_LP_MB: begin
                    r_acc   <= r_acc + ACC_W'(w_fb_prod);
                    r_state <= ST_LP_MD;
                end
                ST_LP_MD: begin
                    r_acc   <= ACC_W'(w_fd_prod);
                    r_state <= ST_LP_WR;
                end
                ST_LP_WR: begin
                    r_filt  <= w_dnew;
                    r_pos   <= w_pos_nx;
                    r_phase <= r_phase - {1'b0, r_stride};
                    r_state <= ST_LP_CHK;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
